// File: rtl/csvt_pkg.sv
// Shared types and constants for the CSV record tokenizer.
// No dependencies; every rtl file takes names from here by csvt_pkg:: scope.
package csvt_pkg;

   // Parser position within a record, one-hot
   typedef enum logic [5:0] {
      MODE_START   = 6'b000001,  // field start, no open field
      MODE_PLAIN   = 6'b000010,  // inside unquoted field
      MODE_QUOTED  = 6'b000100,  // inside quoted field
      MODE_QSEEN   = 6'b001000,  // quote seen inside quoted field
      MODE_SKIP    = 6'b010000,  // drop the byte after CR
      MODE_DISCARD = 6'b100000   // drop through the next CR
   } mode_type;

   // Result kinds
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_FIELD  = 2'd1;
   localparam logic [1:0] KIND_RECORD = 2'd2;

   // Characters of interest
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // Work for one request, emitted in order: field end, CR, data byte, record end
   typedef struct packed {
      logic       has_field;
      logic       has_data;
      logic       data_crlf;   // data byte is LF, precede it with CR
      logic       has_record;
      logic [7:0] data;
   } cmd_type;

endpackage

// File: rtl/csvt_front.sv
// Front end of the CSV tokenizer: accepts request bytes, tracks parse mode
// and turns each byte into a command for the back end. Uses csvt_pkg.
module csvt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              queue_full,
   output logic              push,
   output csvt_pkg::cmd_type cmd
);

   csvt_pkg::mode_type mode_ff, mode_in;
   logic accept;
   logic is_cr, is_lf, is_comma, is_quote, is_nul;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   assign is_cr    = (req_tdata == csvt_pkg::CH_CR);
   assign is_lf    = (req_tdata == csvt_pkg::CH_LF);
   assign is_comma = (req_tdata == csvt_pkg::CH_COMMA);
   assign is_quote = (req_tdata == csvt_pkg::CH_QUOTE);
   assign is_nul   = (req_tdata == csvt_pkg::CH_NUL);

   always_comb begin
      cmd         = '0;
      cmd.data    = req_tdata;
      mode_in     = mode_ff;
      case (mode_ff)
         csvt_pkg::MODE_SKIP: begin
            mode_in = csvt_pkg::MODE_START;
         end
         csvt_pkg::MODE_DISCARD: begin
            if (is_cr) mode_in = csvt_pkg::MODE_SKIP;
         end
         csvt_pkg::MODE_START: begin
            if (is_cr) begin
               cmd.has_record = 1'b1;
               mode_in        = csvt_pkg::MODE_SKIP;
            end else if (is_nul) begin
               cmd.has_record = 1'b1;
               mode_in        = csvt_pkg::MODE_DISCARD;
            end else if (is_comma) begin
               cmd.has_field  = 1'b1;
            end else if (is_quote) begin
               mode_in        = csvt_pkg::MODE_QUOTED;
            end else begin
               cmd.has_data   = 1'b1;
               mode_in        = csvt_pkg::MODE_PLAIN;
            end
         end
         csvt_pkg::MODE_PLAIN: begin
            if (is_cr || is_nul) begin
               cmd.has_field  = 1'b1;
               cmd.has_record = 1'b1;
               mode_in = is_cr ? csvt_pkg::MODE_SKIP : csvt_pkg::MODE_DISCARD;
            end else if (is_comma) begin
               cmd.has_field  = 1'b1;
               mode_in        = csvt_pkg::MODE_START;
            end else begin
               cmd.has_data   = 1'b1;
            end
         end
         csvt_pkg::MODE_QUOTED: begin
            if (is_cr || is_nul) begin
               cmd.has_field  = 1'b1;
               cmd.has_record = 1'b1;
               mode_in = is_cr ? csvt_pkg::MODE_SKIP : csvt_pkg::MODE_DISCARD;
            end else if (is_quote) begin
               mode_in        = csvt_pkg::MODE_QSEEN;
            end else begin
               cmd.has_data   = 1'b1;
            end
         end
         csvt_pkg::MODE_QSEEN: begin
            if (is_quote) begin
               // doubled quote: one literal quote
               cmd.has_data   = 1'b1;
               mode_in        = csvt_pkg::MODE_QUOTED;
            end else begin
               cmd.has_field  = 1'b1;
               if (is_cr) begin
                  cmd.has_record = 1'b1;
                  mode_in        = csvt_pkg::MODE_SKIP;
               end else if (is_nul) begin
                  cmd.has_record = 1'b1;
                  mode_in        = csvt_pkg::MODE_DISCARD;
               end else if (is_comma) begin
                  mode_in        = csvt_pkg::MODE_START;
               end else begin
                  cmd.has_data   = 1'b1;
                  mode_in        = csvt_pkg::MODE_PLAIN;
               end
            end
         end
         default: begin
            mode_in = csvt_pkg::MODE_START;
         end
      endcase
      cmd.data_crlf = cmd.has_data && is_lf;
   end

   // bytes that cause no result leave nothing in the queue
   assign push = accept &&
                 (cmd.has_field || cmd.has_data || cmd.has_record);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= csvt_pkg::MODE_START;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

// File: rtl/csvt_queue.sv
// Small command queue between tokenizer front and back end.
// Register-based, head read combinationally from the slots. Uses csvt_pkg.
module csvt_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  csvt_pkg::cmd_type push_cmd,
   input  logic              pop,
   output csvt_pkg::cmd_type head,
   output logic              head_valid,
   output logic              full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   csvt_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign head       = slot_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/csvt_back.sv
// Back end of the CSV tokenizer: expands the queue head into results,
// one per cycle while the output is ready, into a registered response stage. Uses csvt_pkg.
module csvt_back (
   input  logic              clock,
   input  logic              reset,
   input  csvt_pkg::cmd_type head,
   input  logic              head_valid,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_byte
   output logic [1:0]        rsp_tuser,   // [1:0] out_kind
   output logic              rsp_tlast    // last
);

   // pieces: 0 field end, 1 CR before LF, 2 data byte, 3 record end
   logic [3:0] done_ff, done_in;
   logic [3:0] piece_en, pending, sel;
   logic       advance, take, last_piece;

   logic       rsp_valid_ff;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff;

   assign piece_en   = {head.has_record, head.has_data, head.data_crlf, head.has_field};
   assign pending    = piece_en & ~done_ff;
   assign sel        = pending & (~pending + 4'd1);
   assign last_piece = ((pending & ~sel) == 4'd0);

   assign advance = !rsp_valid_ff || rsp_tready;
   assign take    = advance && head_valid;
   assign pop     = take && last_piece;

   always_comb begin
      kind_in = csvt_pkg::KIND_DATA;
      byte_in = 8'd0;
      if (sel[0]) begin
         kind_in = csvt_pkg::KIND_FIELD;
      end else if (sel[1]) begin
         byte_in = csvt_pkg::CH_CR;
      end else if (sel[2]) begin
         byte_in = head.data;
      end else begin
         kind_in = csvt_pkg::KIND_RECORD;
      end
      done_in = done_ff;
      if (take) begin
         done_in = last_piece ? 4'd0 : (done_ff | sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (advance) rsp_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         last_ff <= last_piece;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: rtl/csv_record_tokenizer_unit.sv
// Top level of the CSV record tokenizer: front end, command queue, back end.
// Depends on csvt_pkg, csvt_front, csvt_queue and csvt_back.
//
// Usage:
//   req_* : one raw text byte per request (req_tdata[7:0]).
//   rsp_* : one result per response on the output side: rsp_tuser[1:0] is the
//           kind (0 data byte, 1 end of field, 2 end of record), rsp_tdata[7:0]
//           the data byte (zero for marks), rsp_tlast marks the final result a
//           byte caused. A byte may cause zero to three results.
//   Path: an accepted byte is written into a queue slot register; its first
//   result is then registered into the response stage when the output is free.
//   Throughput: one request per cycle while each byte yields at most one
//   result and rsp_tready stays high; the back end drains one result per
//   cycle while rsp_tready is high; a multi-result byte holds the queue head.
//   The queue of QUEUE_DEPTH commands absorbs the difference; the front stalls
//   (req_tready low) only when it is full. Bytes with no result take no slot.
//   Stall: with rsp_tready low the response register holds its result and
//   the queue fills; input stalls once it is full.
//   Reset (synchronous, active high): parser returns to field start, queue
//   and response stage are emptied.
module csv_record_tokenizer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic [1:0]  rsp_tuser,    // [1:0] out_kind
   output logic        rsp_tlast     // last
);

   csvt_pkg::cmd_type push_cmd, head;
   logic push, pop, head_valid, queue_full;

   // parse mode tracking and classification of each byte
   csvt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   // decouples the parser from output stalls
   csvt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   // result expansion and registered response
   csvt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
